>>> src/pkmh_pkg.sv
// ----------------------------------------------------------------------------
// pkmh_pkg
// shared sizes, hash constants and types of the pair-key memo hash table
// ----------------------------------------------------------------------------
package pkmh_pkg;

   localparam int SLOTS      = 1024;
   localparam int VALUE_BITS = 32;
   localparam int ENTRIES    = SLOTS / 2;

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int ENTRY_W = $clog2(ENTRIES);
   localparam int COUNT_W = $clog2(ENTRIES + 1);

   localparam int HASH_SHIFT = 32;
   localparam int SCALE_W    = HASH_SHIFT + SLOT_W + 1;

   localparam logic [HASH_SHIFT-1:0] HASH_MUL_X = HASH_SHIFT'(7);
   localparam logic [KEY_W-1:0]      HASH_MUL_Y = 64'd10495464745870458733;

   localparam int VALUE_KEEP = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam logic [VALUE_W-1:0] VALUE_MASK =
      VALUE_W'(((VALUE_W + 1)'(1) << VALUE_KEEP) - (VALUE_W + 1)'(1));

   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SLOTS - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(ENTRIES);

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef struct packed {
      logic               valid;
      logic [ENTRY_W-1:0] index;
   } slot_entry_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key_left;
      logic [KEY_W-1:0]   key_right;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SLOT_CHK,
      ST_ENTRY_CHK,
      ST_RESULT
   } state_type;

endpackage

>>> src/pkmh_req_if.sv
// ----------------------------------------------------------------------------
// pkmh_req_if
// request channel: one lookup or insert per beat
// ----------------------------------------------------------------------------
interface pkmh_req_if;

   logic                                  valid;
   logic                                  ready;
   logic                                  op;
   logic signed [pkmh_pkg::KEY_W-1:0]     key_left;
   logic signed [pkmh_pkg::KEY_W-1:0]     key_right;
   logic        [pkmh_pkg::VALUE_W-1:0]   value_in;

   modport source (output valid, op, key_left, key_right, value_in, input ready);
   modport sink   (input valid, op, key_left, key_right, value_in, output ready);

endinterface

>>> src/pkmh_rsp_if.sv
// ----------------------------------------------------------------------------
// pkmh_rsp_if
// response channel: one result per request beat
// ----------------------------------------------------------------------------
interface pkmh_rsp_if;

   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [pkmh_pkg::VALUE_W-1:0]    value_out;
   logic                            table_full;

   modport source (output valid, hit, value_out, table_full, input ready);
   modport sink   (input valid, hit, value_out, table_full, output ready);

endinterface

>>> src/pkmh_ram.sv
// ----------------------------------------------------------------------------
// pkmh_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pkmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pkmh_hash.sv
// ----------------------------------------------------------------------------
// pkmh_hash
// two-stage start slot unit: key mix, then scale to the slot range
// ----------------------------------------------------------------------------
module pkmh_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [pkmh_pkg::HASH_SHIFT-1:0] left_lo,
   input  logic [pkmh_pkg::HASH_SHIFT-1:0] right_lo,
   output logic                            done,
   output logic [pkmh_pkg::SLOT_W-1:0]     slot
);

   import pkmh_pkg::*;

   logic                  s1_valid_ff;
   logic                  s2_valid_ff;
   logic [HASH_SHIFT-1:0] prod_ff;
   logic [HASH_SHIFT-1:0] prod_in;
   logic [HASH_SHIFT-1:0] x7_ff;
   logic [HASH_SHIFT-1:0] x7_in;
   logic [HASH_SHIFT-1:0] mix;
   logic [SCALE_W-1:0]    scaled_ff;
   logic [SCALE_W-1:0]    scaled_in;

   assign prod_in   = HASH_SHIFT'(right_lo * HASH_MUL_Y[HASH_SHIFT-1:0]);
   assign x7_in     = HASH_SHIFT'(left_lo * HASH_MUL_X);
   assign mix       = HASH_SHIFT'(prod_ff + x7_ff);
   assign scaled_in = SCALE_W'(SCALE_W'(mix) * SCALE_W'(SLOTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= go;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      x7_ff     <= x7_in;
      scaled_ff <= scaled_in;
   end

   assign done = s2_valid_ff;
   assign slot = scaled_ff[HASH_SHIFT +: SLOT_W];

endmodule

>>> src/pair_key_memo_hash_table.sv
// ----------------------------------------------------------------------------
// pair_key_memo_hash_table
// memo cache keyed by a pair of 64-bit integers, linear probing slot table
// flow: the beat is hashed to a start slot and the slot ram is probed downward, wrapping;
//   an insert into a full table is refused without probing, an insert takes the first free slot,
//   a lookup checks the entry of each occupied slot up to a key match or a free slot
// handshake: one item at a time; the next beat is taken once the result sits in the
//   output register
// reset: clearing pass over the whole slot ram, no beat taken meanwhile
// ----------------------------------------------------------------------------
module pair_key_memo_hash_table (
   input  logic       clock,
   input  logic       reset,
   pkmh_req_if.sink   req_chan,
   pkmh_rsp_if.source rsp_chan
);

   import pkmh_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [SLOT_W-1:0]  probe_ff;
   logic [SLOT_W-1:0]  probe_in;
   logic [SLOT_W-1:0]  probe_next;
   logic [SLOT_W-1:0]  clr_ff;
   logic [SLOT_W-1:0]  clr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic               op_ff;
   logic [KEY_W-1:0]   left_ff;
   logic [KEY_W-1:0]   right_ff;
   logic [VALUE_W-1:0] value_ff;

   logic               res_hit_ff;
   logic               res_hit_in;
   logic [VALUE_W-1:0] res_value_ff;
   logic [VALUE_W-1:0] res_value_in;
   logic               res_full_ff;
   logic               res_full_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_hit_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_full_ff;
   logic               rsp_load;

   logic               req_ready;
   logic               req_take;
   logic               hash_done;
   logic [SLOT_W-1:0]  hash_slot;

   logic               slot_wr_en;
   logic [SLOT_W-1:0]  slot_wr_addr;
   slot_entry_type     slot_wr_data;
   slot_entry_type     slot_rd_data;
   logic               entry_wr_en;
   entry_type          entry_wr_data;
   entry_type          entry_rd_data;
   logic               key_match;

   assign req_take = req_chan.valid && req_ready;

   pkmh_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .go       (req_take),
      .left_lo  (req_chan.key_left[HASH_SHIFT-1:0]),
      .right_lo (req_chan.key_right[HASH_SHIFT-1:0]),
      .done     (hash_done),
      .slot     (hash_slot)
   );

   pkmh_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (probe_in),
      .rd_data (slot_rd_data)
   );

   assign entry_wr_data = '{key_left: left_ff, key_right: right_ff, value: value_ff};

   pkmh_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (count_ff[ENTRY_W-1:0]),
      .wr_data (entry_wr_data),
      .rd_addr (slot_rd_data.index),
      .rd_data (entry_rd_data)
   );

   assign probe_next = (probe_ff == '0) ? SLOT_LAST : SLOT_W'(probe_ff - 1'b1);
   assign key_match  = (entry_rd_data.key_left == left_ff)
                    && (entry_rd_data.key_right == right_ff);
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      res_hit_in   = res_hit_ff;
      res_value_in = res_value_ff;
      res_full_in  = res_full_ff;
      req_ready    = 1'b0;
      slot_wr_en   = 1'b0;
      slot_wr_addr = probe_ff;
      slot_wr_data = '{valid: 1'b1, index: count_ff[ENTRY_W-1:0]};
      entry_wr_en  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = clr_ff;
            slot_wr_data = '0;
            clr_in       = SLOT_W'(clr_ff + 1'b1);
            if (clr_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               if (op_ff == OP_INSERT && count_ff == COUNT_FULL) begin
                  res_hit_in   = 1'b0;
                  res_value_in = '0;
                  res_full_in  = 1'b1;
                  state_in     = ST_RESULT;
               end else begin
                  probe_in = hash_slot;
                  state_in = ST_SLOT_CHK;
               end
            end
         end
         ST_SLOT_CHK: begin
            if (!slot_rd_data.valid) begin
               res_full_in = 1'b0;
               if (op_ff == OP_INSERT) begin
                  slot_wr_en   = 1'b1;
                  entry_wr_en  = 1'b1;
                  count_in     = COUNT_W'(count_ff + 1'b1);
                  res_hit_in   = 1'b1;
                  res_value_in = value_ff;
               end else begin
                  res_hit_in   = 1'b0;
                  res_value_in = '0;
               end
               state_in = ST_RESULT;
            end else if (op_ff == OP_INSERT) begin
               probe_in = probe_next;
            end else begin
               state_in = ST_ENTRY_CHK;
            end
         end
         ST_ENTRY_CHK: begin
            if (key_match) begin
               res_hit_in   = 1'b1;
               res_value_in = entry_rd_data.value;
               res_full_in  = 1'b0;
               state_in     = ST_RESULT;
            end else begin
               probe_in = probe_next;
               state_in = ST_SLOT_CHK;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff     <= probe_in;
      res_hit_ff   <= res_hit_in;
      res_value_ff <= res_value_in;
      res_full_ff  <= res_full_in;
      if (req_take) begin
         op_ff    <= req_chan.op;
         left_ff  <= req_chan.key_left;
         right_ff <= req_chan.key_right;
         value_ff <= req_chan.value_in & VALUE_MASK;
      end
      if (rsp_load) begin
         rsp_hit_ff   <= res_hit_ff;
         rsp_value_ff <= res_value_ff;
         rsp_full_ff  <= res_full_ff;
      end
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.value_out  = rsp_value_ff;
   assign rsp_chan.table_full = rsp_full_ff;

endmodule
